// ----- rtl/core/irc_line_field_splitter_core_assert.svh -----
// ----------------------------------------------------------------------------
// irc_line_field_splitter_core_assert.svh
// Assertion macros for the line field splitter, empty when SYNTH is set
// ----------------------------------------------------------------------------
`ifndef IRC_LINE_FIELD_SPLITTER_CORE_ASSERT_SVH
`define IRC_LINE_FIELD_SPLITTER_CORE_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication
`define IRCLFS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("irclfs same-cycle check failed");

// next-cycle implication
`define IRCLFS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("irclfs next-cycle check failed");

`else

`define IRCLFS_ASSERT_IMP(label, ante, cons)
`define IRCLFS_ASSERT_NXT(label, ante, cons)

`endif

`endif

// ----- rtl/core/irclfs_pkg.sv -----
// ----------------------------------------------------------------------------
// irclfs_pkg
// Types and constants shared by the line field splitter modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package irclfs_pkg;

    localparam int POS_W  = 9;
    localparam int EPOS_W = 10;
    localparam int PNUM_W = 4;

    localparam logic [POS_W-1:0] LEN_MAX = 9'h1FF;

    // characters
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // field kinds
    localparam logic [2:0] KIND_NICK  = 3'd0;
    localparam logic [2:0] KIND_USER  = 3'd1;
    localparam logic [2:0] KIND_HOST  = 3'd2;
    localparam logic [2:0] KIND_CMD   = 3'd3;
    localparam logic [2:0] KIND_PARAM = 3'd4;
    localparam logic [2:0] KIND_BODY  = 3'd5;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        MODE_LINE_START  = 3'd0,
        MODE_PREFIX      = 3'd1,
        MODE_CMD         = 3'd2,
        MODE_PARAM_START = 3'd3,
        MODE_PARAM       = 3'd4,
        MODE_BODY        = 3'd5
    } t_mode;

    typedef enum logic {
        JOB_SPAN   = 1'b0,
        JOB_PREFIX = 1'b1
    } t_job_kind;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       line_end;
    } t_in;

    typedef struct packed {
        logic [2:0]        field_kind;
        logic [POS_W-1:0]  field_start;
        logic [POS_W-1:0]  field_length;
        logic [PNUM_W-1:0] param_number;
        logic              overflow_seen;
        logic              last_of_line;
    } t_out;

    // one emission of the parser: a single span or a whole prefix
    typedef struct packed {
        t_job_kind         jtype;
        logic [2:0]        kind;
        logic [EPOS_W-1:0] start;
        logic [EPOS_W-1:0] stop;
        logic              bang_seen;
        logic [POS_W-1:0]  bang_pos;
        logic              at_seen;
        logic [POS_W-1:0]  at_pos;
        logic [PNUM_W-1:0] pnum;
        logic              ovf;
        logic              last;
    } t_job;

endpackage

// ----- rtl/core/irc_line_field_splitter_core.sv -----
// ----------------------------------------------------------------------------
// irc_line_field_splitter_core
// A field passes the job queue, then the output register. Throughput: one
// byte per cycle while the queue has room; the span unit emits one result per
// cycle unless stalled, so a prefix's three spans are absorbed by a 4-entry
// job queue. Reset is synchronous, active low, and returns the parser to line
// start with the queue and output register empty; no clearing pass follows.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "irc_line_field_splitter_core_assert.svh"

module irc_line_field_splitter_core #(
    parameter int MAX_LINE   = 512,
    parameter int MAX_PARAMS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  irclfs_pkg::t_in   i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output irclfs_pkg::t_out  o_data
);
    import irclfs_pkg::*;

    localparam int POS_CAP = ((MAX_LINE - 1) < 511) ? (MAX_LINE - 1) : 511;

    logic w_q_not_full;
    logic w_push;
    t_job w_push_job;
    logic w_q_valid;
    t_job w_head_job;
    logic w_pop;

    irclfs_front #(
        .MAX_LINE   (MAX_LINE),
        .MAX_PARAMS (MAX_PARAMS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_data    (i_data),
        .i_q_ready (w_q_not_full),
        .o_push    (w_push),
        .o_job     (w_push_job)
    );

    irclfs_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_job      (w_push_job),
        .o_not_full (w_q_not_full),
        .i_pop      (w_pop),
        .o_valid    (w_q_valid),
        .o_job      (w_head_job)
    );

    irclfs_back #(
        .MAX_LINE (MAX_LINE)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_job     (w_head_job),
        .o_pop     (w_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_data    (o_data)
    );

    // parameter index only on parameter fields
    `IRCLFS_ASSERT_IMP(a_pnum_only_param, o_valid && (o_data.field_kind != KIND_PARAM), o_data.param_number == '0)
    // a reported span never runs past the end of the line
    `IRCLFS_ASSERT_IMP(a_span_in_line, o_valid, (10'(o_data.field_start) + 10'(o_data.field_length)) <= 10'(POS_CAP + 1))
    // every line end leaves work queued for the span unit
    `IRCLFS_ASSERT_NXT(a_line_end_queued, i_valid && o_ready && i_data.line_end, w_q_valid)

endmodule

// ----- rtl/core/irclfs_front.sv -----
// ----------------------------------------------------------------------------
// irclfs_front
// Byte parser: tracks the line state and turns field boundaries into jobs
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module irclfs_front #(
    parameter int MAX_LINE   = 512,
    parameter int MAX_PARAMS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  irclfs_pkg::t_in   i_data,
    input  logic              i_q_ready,
    output logic              o_push,
    output irclfs_pkg::t_job  o_job
);
    import irclfs_pkg::*;

    localparam int POS_CAP   = ((MAX_LINE - 1) < 511) ? (MAX_LINE - 1) : 511;
    localparam int PARAM_CAP = (MAX_PARAMS < 16) ? MAX_PARAMS : 16;
    localparam logic [POS_W-1:0]  POS_CAP_V   = POS_W'(POS_CAP);
    localparam logic [PNUM_W-1:0] PCOUNT_LAST = PNUM_W'(PARAM_CAP - 1);

    t_mode             r_mode, n_mode;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [EPOS_W-1:0] r_ts, n_ts;
    logic [POS_W-1:0]  r_bang_pos, n_bang_pos;
    logic              r_bang_seen, n_bang_seen;
    logic [POS_W-1:0]  r_at_pos, n_at_pos;
    logic              r_at_seen, n_at_seen;
    logic [PNUM_W-1:0] r_pcount, n_pcount;
    logic              r_ovf, n_ovf;
    logic              r_pfull, n_pfull;

    logic              w_acc;
    logic              w_last;
    logic              w_sp;
    logic [EPOS_W-1:0] w_p;
    logic [EPOS_W-1:0] w_p1;
    logic [EPOS_W-1:0] w_ts;
    t_mode             w_st;
    logic              w_skip;
    logic              w_param;
    logic [EPOS_W-1:0] w_param_s;
    logic [EPOS_W-1:0] w_param_e;

    assign o_ready = i_q_ready;
    assign w_acc   = i_valid && i_q_ready;
    assign w_last  = i_data.line_end;
    assign w_sp    = (i_data.byte_in == CH_SPACE);
    assign w_p     = {1'b0, r_pos};
    assign w_p1    = w_p + EPOS_W'(1);

    always_comb begin
        n_mode      = r_mode;
        n_pos       = r_pos;
        n_ts        = r_ts;
        n_bang_pos  = r_bang_pos;
        n_bang_seen = r_bang_seen;
        n_at_pos    = r_at_pos;
        n_at_seen   = r_at_seen;
        n_pcount    = r_pcount;
        n_ovf       = r_ovf;
        n_pfull     = r_pfull;
        o_push      = 1'b0;
        o_job       = '0;
        w_ts        = r_ts;
        w_st        = r_mode;
        w_skip      = 1'b0;
        w_param     = 1'b0;
        w_param_s   = '0;
        w_param_e   = '0;

        if (w_acc) begin
            if (w_st == MODE_LINE_START) begin
                if (i_data.byte_in == CH_COLON) begin
                    w_skip      = 1'b1;
                    n_mode      = MODE_PREFIX;
                    n_ts        = w_p1;
                    n_bang_seen = 1'b0;
                    n_at_seen   = 1'b0;
                    if (w_last) begin
                        o_push      = 1'b1;
                        o_job.jtype = JOB_SPAN;
                        o_job.kind  = KIND_NICK;
                        o_job.start = w_p1;
                        o_job.stop  = w_p1;
                    end
                end else begin
                    w_st   = MODE_CMD;
                    w_ts   = w_p;
                    n_mode = MODE_CMD;
                    n_ts   = w_p;
                end
            end

            if (!w_skip) begin
                case (w_st)
                    MODE_PREFIX: begin
                        if (!w_sp) begin
                            if (i_data.byte_in == CH_AT && !r_at_seen) begin
                                n_at_seen = 1'b1;
                                n_at_pos  = r_pos;
                            end else if (i_data.byte_in == CH_BANG && !r_bang_seen
                                         && !r_at_seen) begin
                                n_bang_seen = 1'b1;
                                n_bang_pos  = r_pos;
                            end
                        end
                        if (w_sp || w_last) begin
                            o_push          = 1'b1;
                            o_job.jtype     = JOB_PREFIX;
                            o_job.kind      = KIND_NICK;
                            o_job.start     = w_ts;
                            o_job.stop      = w_sp ? w_p : w_p1;
                            o_job.bang_seen = n_bang_seen;
                            o_job.bang_pos  = n_bang_pos;
                            o_job.at_seen   = n_at_seen;
                            o_job.at_pos    = n_at_pos;
                        end
                        if (w_sp) begin
                            n_mode = MODE_CMD;
                            n_ts   = w_p1;
                        end
                    end
                    MODE_CMD: begin
                        if (w_sp || w_last) begin
                            o_push      = 1'b1;
                            o_job.jtype = JOB_SPAN;
                            o_job.kind  = KIND_CMD;
                            o_job.start = w_ts;
                            o_job.stop  = w_sp ? w_p : w_p1;
                        end
                        if (w_sp) begin
                            n_mode = MODE_PARAM_START;
                            n_ts   = w_p1;
                        end
                    end
                    MODE_PARAM_START: begin
                        if (i_data.byte_in == CH_COLON) begin
                            n_mode = MODE_BODY;
                            n_ts   = w_p1;
                            if (w_last) begin
                                o_push      = 1'b1;
                                o_job.jtype = JOB_SPAN;
                                o_job.kind  = KIND_BODY;
                                o_job.start = w_p1;
                                o_job.stop  = w_p1;
                            end
                        end else if (w_sp) begin
                            // double space: empty parameter
                            w_param   = 1'b1;
                            w_param_s = w_p;
                            w_param_e = w_p;
                            n_ts      = w_p1;
                        end else begin
                            n_mode = MODE_PARAM;
                            n_ts   = w_p;
                            if (w_last) begin
                                w_param   = 1'b1;
                                w_param_s = w_p;
                                w_param_e = w_p1;
                            end
                        end
                    end
                    MODE_PARAM: begin
                        if (w_sp || w_last) begin
                            w_param   = 1'b1;
                            w_param_s = w_ts;
                            w_param_e = w_sp ? w_p : w_p1;
                        end
                        if (w_sp) begin
                            n_mode = MODE_PARAM_START;
                            n_ts   = w_p1;
                        end
                    end
                    default: begin
                        // body runs to the end of the line
                        if (w_last) begin
                            o_push      = 1'b1;
                            o_job.jtype = JOB_SPAN;
                            o_job.kind  = KIND_BODY;
                            o_job.start = w_ts;
                            o_job.stop  = w_p1;
                        end
                    end
                endcase
            end

            if (w_param) begin
                o_push      = 1'b1;
                o_job.jtype = JOB_SPAN;
                o_job.kind  = KIND_PARAM;
                o_job.start = w_param_s;
                o_job.stop  = w_param_e;
                o_job.pnum  = r_pcount;
                if (r_pfull) begin
                    n_ovf = 1'b1;
                end
                if (r_pcount >= PCOUNT_LAST) begin
                    n_pfull = 1'b1;
                end else begin
                    n_pcount = r_pcount + PNUM_W'(1);
                end
            end
            o_job.ovf  = r_ovf || (w_param && r_pfull);
            o_job.last = w_last;

            if (w_last) begin
                n_mode      = MODE_LINE_START;
                n_pos       = '0;
                n_ts        = '0;
                n_bang_pos  = '0;
                n_bang_seen = 1'b0;
                n_at_pos    = '0;
                n_at_seen   = 1'b0;
                n_pcount    = '0;
                n_ovf       = 1'b0;
                n_pfull     = 1'b0;
            end else if (r_pos >= POS_CAP_V) begin
                // long line: position sticks at the cap
                n_pos = POS_CAP_V;
                n_ovf = 1'b1;
            end else begin
                n_pos = r_pos + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_LINE_START;
            r_pos       <= '0;
            r_ts        <= '0;
            r_bang_pos  <= '0;
            r_bang_seen <= 1'b0;
            r_at_pos    <= '0;
            r_at_seen   <= 1'b0;
            r_pcount    <= '0;
            r_ovf       <= 1'b0;
            r_pfull     <= 1'b0;
        end else begin
            r_mode      <= n_mode;
            r_pos       <= n_pos;
            r_ts        <= n_ts;
            r_bang_pos  <= n_bang_pos;
            r_bang_seen <= n_bang_seen;
            r_at_pos    <= n_at_pos;
            r_at_seen   <= n_at_seen;
            r_pcount    <= n_pcount;
            r_ovf       <= n_ovf;
            r_pfull     <= n_pfull;
        end
    end

endmodule

// ----- rtl/core/irclfs_queue.sv -----
// ----------------------------------------------------------------------------
// irclfs_queue
// Short job queue between the parser and the span generator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module irclfs_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  irclfs_pkg::t_job  i_job,
    output logic              o_not_full,
    input  logic              i_pop,
    output logic              o_valid,
    output irclfs_pkg::t_job  o_job
);
    import irclfs_pkg::*;

    t_job                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_AW:0]   r_count, n_count;

    assign o_not_full = (r_count != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid    = (r_count != '0);
    assign o_job      = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + QUEUE_AW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + QUEUE_AW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + (QUEUE_AW+1)'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - (QUEUE_AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ----- rtl/core/irclfs_back.sv -----
// ----------------------------------------------------------------------------
// irclfs_back
// Span generator: expands each job into field results, one per unstalled cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module irclfs_back #(
    parameter int MAX_LINE = 512
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  irclfs_pkg::t_job  i_job,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output irclfs_pkg::t_out  o_data
);
    import irclfs_pkg::*;

    localparam int POS_CAP = ((MAX_LINE - 1) < 511) ? (MAX_LINE - 1) : 511;
    localparam logic [EPOS_W-1:0] POS_CAP_E = EPOS_W'(POS_CAP);

    logic              r_valid;
    t_out              r_data, n_data;
    logic [1:0]        r_idx, n_idx;
    logic              r_sticky, n_sticky;

    logic              w_load;
    logic              w_last_span;
    logic [1:0]        w_host_idx;
    logic [2:0]        w_kind;
    logic [EPOS_W-1:0] w_s;
    logic [EPOS_W-1:0] w_e;
    logic [EPOS_W-1:0] w_len;
    logic              w_clip;

    assign w_load     = i_q_valid && (!r_valid || i_ready);
    assign o_pop      = w_load && w_last_span;
    assign o_valid    = r_valid;
    assign o_data     = r_data;
    assign w_host_idx = i_job.bang_seen ? 2'd2 : 2'd1;

    always_comb begin
        w_last_span = (r_idx == 2'd0);
        w_kind      = i_job.kind;
        w_s         = i_job.start;
        w_e         = i_job.stop;
        if (i_job.jtype == JOB_PREFIX) begin
            if (i_job.at_seen) begin
                w_last_span = (r_idx == w_host_idx);
            end
            if (i_job.at_seen && i_job.bang_seen && r_idx == 2'd1) begin
                w_kind = KIND_USER;
                w_s    = {1'b0, i_job.bang_pos} + EPOS_W'(1);
                w_e    = {1'b0, i_job.at_pos};
            end else if (i_job.at_seen && r_idx == w_host_idx) begin
                w_kind = KIND_HOST;
                w_s    = {1'b0, i_job.at_pos} + EPOS_W'(1);
                w_e    = i_job.stop;
            end else begin
                w_kind = KIND_NICK;
                w_s    = i_job.start;
                if (i_job.at_seen) begin
                    w_e = i_job.bang_seen ? {1'b0, i_job.bang_pos} : {1'b0, i_job.at_pos};
                end
            end
        end
    end

    always_comb begin
        w_len  = (w_e > w_s) ? (w_e - w_s) : '0;
        w_clip = (w_len > {1'b0, LEN_MAX});

        n_data.field_kind    = w_kind;
        n_data.field_start   = (w_s > POS_CAP_E) ? POS_CAP_E[POS_W-1:0] : w_s[POS_W-1:0];
        n_data.field_length  = w_clip ? LEN_MAX : w_len[POS_W-1:0];
        n_data.param_number  = i_job.pnum;
        n_data.overflow_seen = i_job.ovf || r_sticky || w_clip;
        n_data.last_of_line  = i_job.last && w_last_span;

        n_idx    = r_idx;
        n_sticky = r_sticky;
        if (w_load) begin
            n_idx = w_last_span ? 2'd0 : (r_idx + 2'd1);
            // clipped lengths stay flagged until the line is done
            if (i_job.last && w_last_span) begin
                n_sticky = 1'b0;
            end else begin
                n_sticky = r_sticky || w_clip;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_idx    <= '0;
            r_sticky <= 1'b0;
        end else begin
            r_idx    <= n_idx;
            r_sticky <= n_sticky;
            if (w_load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data <= n_data;
        end
    end

endmodule
